FILE: hw/rtl/mkdb_pkg.sv
// Package for the eight-key debounce and long-press detector.
// Holds key phase and event code types, the request slot struct and the key pin map.
// No dependencies.
package mkdb_pkg;

  localparam int NUM_KEYS = 8;
  localparam int KEY_W    = 3;
  localparam int PORT_W   = 8;
  localparam int BIT_W    = 3;
  localparam int DEB_W    = 8;
  localparam int LONG_W   = 16;
  localparam int CFG_W    = 16;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_PRESS      = 2'd0,
    EV_LONG_START = 2'd1,
    EV_SHORT      = 2'd2,
    EV_RELEASE    = 2'd3
  } ev_code_t;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_reg_t;

  // one pending event request in the drain chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    ev_code_t         code;
  } slot_t;

  // port select (0 = E, 1 = D) and bit number, in scan order
  localparam logic [NUM_KEYS-1:0] KEY_PORT_D = 8'b0000_1100;
  localparam logic [NUM_KEYS-1:0][BIT_W-1:0] KEY_BIT = {
    3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd6, 3'd7
  };

  localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd3;
  localparam logic [LONG_W-1:0] LONG_RESET = 16'd50;

endpackage

FILE: hw/rtl/mkdb_key_cell.sv
// One key cell: phase machine, saturating tick counter and two event slots.
// Slots shift toward key 0 each drain cycle. Depends on mkdb_pkg.
module mkdb_key_cell #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mkdb_pkg::KEY_W-1:0]           key_id,
  input  logic                                 load,
  input  logic                                 shift,
  input  logic                                 active,
  input  logic [mkdb_pkg::DEB_W-1:0]           deb_limit,
  input  logic [mkdb_pkg::LONG_W-1:0]          long_limit,
  input  mkdb_pkg::slot_t                      slot_in,
  output mkdb_pkg::slot_t                      slot_out,
  output logic [1:0]                           busy
);
  import mkdb_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > LONG_W) ? COUNTER_WIDTH : LONG_W;

  phase_t                   phase_r, phase_nxt;
  logic [COUNTER_WIDTH-1:0] count_r, count_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_inc;
  logic                     deb_hit, long_hit;
  slot_t                    slot0_r, slot0_nxt;
  slot_t                    slot1_r, slot1_nxt;
  slot_t                    ev0, ev1;

  assign cnt_inc  = (count_r == {COUNTER_WIDTH{1'b1}}) ? count_r : count_r + 1'b1;
  assign deb_hit  = CMP_W'(cnt_inc) >= CMP_W'(deb_limit);
  assign long_hit = CMP_W'(cnt_inc) >= CMP_W'(long_limit);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    case (phase_r)
      PH_IDLE: begin
        if (active) begin
          phase_nxt = PH_DEBOUNCE;
          count_nxt = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (active) begin
          if (deb_hit) begin
            phase_nxt = PH_PRESSED;
            count_nxt = '0;
          end else begin
            count_nxt = cnt_inc;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (active) begin
          count_nxt = cnt_inc;
          if (long_hit) begin
            phase_nxt = PH_LONG;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (!active) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // event outputs
  always_comb begin
    ev0       = '0;
    ev1       = '0;
    ev0.key   = key_id;
    ev1.key   = key_id;
    ev0.code  = EV_PRESS;
    ev1.code  = EV_RELEASE;
    case (phase_r)
      PH_DEBOUNCE: begin
        ev0.valid = active && deb_hit;
      end
      PH_PRESSED: begin
        if (active) begin
          ev0.valid = long_hit;
          ev0.code  = EV_LONG_START;
        end else begin
          ev0.valid = 1'b1;
          ev0.code  = EV_SHORT;
          ev1.valid = 1'b1;
        end
      end
      PH_LONG: begin
        ev0.valid = !active;
        ev0.code  = EV_RELEASE;
      end
      default: begin
        ev0.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      slot0_nxt = ev0;
      slot1_nxt = ev1;
    end else if (shift) begin
      slot0_nxt = slot1_r;
      slot1_nxt = slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      slot0_r <= '0;
      slot1_r <= '0;
    end else begin
      if (load) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
      slot0_r <= slot0_nxt;
      slot1_r <= slot1_nxt;
    end
  end

  assign slot_out = slot0_r;
  assign busy     = {slot1_r.valid, slot0_r.valid};

endmodule

FILE: hw/rtl/multi_key_debounce_long_press_top.sv
// Top level of the eight-key debounce and long-press detector.
// Row of mkdb_key_cell instances feeding an output register. Depends on mkdb_pkg.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata[7:0] port E, [15:8] port D
//  out_    | out | out_tvalid/tready  | out_tdata key, code; out_tlast
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// A scan tick updates all eight keys at the accepting edge and loads up to
// sixteen event requests into the cell row. The row shifts one slot a cycle
// toward key 0 unless a result stalls at the output; in_tready is low while
// any slot is full, so a new tick is taken only once every request of the
// last tick has left the cell row.
// Synchronous active-low reset sets every key idle and the thresholds to 3 and 50.
module multi_key_debounce_long_press_top #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] port_e_byte, [15:8] port_d_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] key_index, [4:3] event_code, [7:5] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  mkdb_pkg::cfg_reg_t          cfg_index,
  input  logic [mkdb_pkg::CFG_W-1:0]  cfg_data
);
  import mkdb_pkg::*;

  logic [DEB_W-1:0]   debounce_r;
  logic [LONG_W-1:0]  long_press_r;
  logic [PORT_W-1:0]  port_e, port_d;
  logic [NUM_KEYS-1:0] active;
  slot_t              chain [NUM_KEYS+1];
  logic [2*NUM_KEYS-1:0] busy;
  logic               load, shift, out_free, rest_busy;
  logic               out_tvalid_r;
  logic [KEY_W-1:0]   out_key_r;
  ev_code_t           out_code_r;
  logic               out_last_r;

  assign port_e = in_tdata[PORT_W-1:0];
  assign port_d = in_tdata[2*PORT_W-1:PORT_W];

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      active[i] = KEY_PORT_D[i] ? port_d[KEY_BIT[i]] : port_e[KEY_BIT[i]];
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEB_RESET;
      long_press_r <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_data[DEB_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = ~|busy;
  assign load      = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign shift     = out_free || !chain[0].valid;
  assign rest_busy = |busy[2*NUM_KEYS-1:1];

  assign chain[NUM_KEYS] = '0;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
    mkdb_key_cell #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_cell (
      .clk              (clk),
      .rst_n            (rst_n),
      .key_id           (KEY_W'(g)),
      .load             (load),
      .shift            (shift),
      .active           (active[g]),
      .deb_limit        (debounce_r),
      .long_limit       (long_press_r),
      .slot_in          (chain[g+1]),
      .slot_out         (chain[g]),
      .busy             (busy[2*g+1:2*g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_free) begin
      out_tvalid_r <= chain[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_key_r  <= chain[0].key;
      out_code_r <= chain[0].code;
      out_last_r <= !rest_busy;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_code_r, out_key_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/mkdb_checker.sv
// Port-level checker for multi_key_debounce_long_press_top, with its bind.
// Depends on mkdb_pkg.
module mkdb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import mkdb_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'b000)
    else $error("padding bits set");

  // more events of this tick pending: no new tick may be taken
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("tick accepted while events pending");

  // short press is always followed by its release
  a_short_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:3] == EV_SHORT |-> !out_tlast)
    else $error("short press marked last");

endmodule

bind multi_key_debounce_long_press_top mkdb_checker u_mkdb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
